/* src/dctcp_wc_pkg.sv */
// ----------------------------------------------------------------------------
// DCTCP window control package
// Register indexes, reset values, sequencer states and the divider status
// word shared by the window control modules.
// ----------------------------------------------------------------------------
package dctcp_wc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_SEG_SIZE        = 2'd0;
	localparam logic [1:0] REG_WINDOW_CEILING  = 2'd1;
	localparam logic [1:0] REG_INIT_WINDOW_REF = 2'd2;

	// Reset values of the configuration registers
	localparam logic [15:0] SEG_SIZE_RST        = 16'd1436;
	localparam logic [31:0] WINDOW_CEILING_RST  = 32'd1048576;
	localparam logic [31:0] INIT_WINDOW_REF_RST = 32'd3000;

	// Event kinds
	localparam logic OP_ACK  = 1'b0;
	localparam logic OP_LOSS = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_CHECK,
		S_CMP,
		S_DIV,
		S_ALPHA,
		S_SCALE,
		S_CLAMP,
		S_DONE
	} wc_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* src/dctcp_window_control.sv */
// ----------------------------------------------------------------------------
// DCTCP window control
// Per-event sender window adjuster: counts ACKs and echoed marks, updates the
// congestion estimate alpha once per window and scales the window by it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event word: op, ce_echo,
//   bypass, cur_window, cur_threshold. Output channel (out_valid/out_ready)
//   returns one result word per event: new_window, new_threshold,
//   window_updated, alpha_out. Configuration (cfg_wr_en/cfg_index/cfg_data)
//   must be written only while the block is idle; the block does not enforce it.
//   Events are handled one at a time. A loss or a bypassed ACK goes from the
//   evaluate state straight to the final state, an ACK below the window
//   boundary passes the check and compare states first, and an ACK that
//   closes the window also runs the restoring divider, which produces one
//   bit of the marked fraction per cycle, then the alpha and scale states;
//   the boundary test and the window scaling share one registered 32-bit multiplier.
//   The result sits in an output register, so a new event is taken as soon as
//   the sequencer is idle even while the receiver stalls; the next result then
//   waits in the final state until the output register drains.
//   Reset clears the counters and alpha, loads the reference window with the
//   reset value of initial_window_ref and returns the registers to defaults.
// ----------------------------------------------------------------------------
module dctcp_window_control #(
	parameter int ALPHA_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// event input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic        ce_echo,
	input  logic        bypass,
	input  logic [31:0] cur_window,
	input  logic [31:0] cur_threshold,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_window,
	output logic [31:0] new_threshold,
	output logic        window_updated,
	output logic [15:0] alpha_out
);

	localparam int F  = ALPHA_FRAC_BITS;
	localparam int MB = (F + 2 > 16) ? F + 2 : 16;   // multiplier B width
	localparam int PW = 32 + MB;                     // product width

	// configuration registers
	logic [15:0] seg_q;
	logic [31:0] ceil_q;

	// sequencer
	dctcp_wc_pkg::wc_state_t state_q, state_d;
	logic div_start;
	dctcp_wc_pkg::div_stat_t div_st;
	logic [F:0] div_quo;

	// persistent state
	logic [31:0] acks_counted_q;
	logic [31:0] acks_marked_q;
	logic [31:0] ref_window_q;
	logic [F-1:0] alpha_q;

	// event held during processing
	logic        op_q;
	logic        ecn_q;
	logic        byp_q;
	logic [31:0] cwnd_q;
	logic [31:0] ssth_q;
	logic        upd_q;

	// output register
	logic        out_valid_q;
	logic [31:0] out_window_q;
	logic [31:0] out_thresh_q;
	logic        out_upd_q;
	logic [15:0] out_alpha_q;

	// shared multiplier
	logic [31:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PW-1:0] mul_q;

	// datapath helpers
	logic [F+1:0]  scale;
	logic [F+4:0]  alpha_sum;
	logic [F-1:0]  alpha_new;
	logic [31:0]   half_win;
	logic [31:0]   floor2;
	logic [31:0]   scaled_win;
	logic [31:0]   clamped_win;
	logic          win_closed;
	logic [F+15:0] alpha_ext;
	logic          out_load;

	// ------------------------------------------------------------------
	// Configuration. initial_window_ref only matters at reset, and reset
	// restores its default, so the reference window always reloads from
	// the default value; writes to it leave no trace.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= dctcp_wc_pkg::SEG_SIZE_RST;
			ceil_q <= dctcp_wc_pkg::WINDOW_CEILING_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				dctcp_wc_pkg::REG_SEG_SIZE:       seg_q  <= cfg_data[15:0];
				dctcp_wc_pkg::REG_WINDOW_CEILING: ceil_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Shared arithmetic
	// ------------------------------------------------------------------
	// scale = 2^(F+1) - alpha
	assign scale = {1'b1, {(F+1){1'b0}}} - {2'b00, alpha_q};

	// boundary test uses counted * seg_size, scaling uses cwnd * scale
	assign mul_a = (state_q == dctcp_wc_pkg::S_CHECK) ? acks_counted_q : cwnd_q;
	assign mul_b = (state_q == dctcp_wc_pkg::S_CHECK) ? MB'(seg_q) : MB'(scale);

	always_ff @(posedge clk) begin
		mul_q <= PW'(mul_a) * PW'(mul_b);
	end

	assign win_closed = (mul_q >= PW'(ref_window_q));

	// alpha = (15 * alpha + f) / 16
	assign alpha_sum = {1'b0, alpha_q, 4'b0000} - (F+5)'(alpha_q) + (F+5)'(div_quo);
	assign alpha_new = alpha_sum[F+3:4];

	// loss threshold floor
	assign half_win = {1'b0, cwnd_q[31:1]};
	assign floor2   = {15'd0, seg_q, 1'b0};

	// drop the scale fraction, then clamp: floor first, then ceiling
	assign scaled_win = mul_q[F+32:F+1];
	always_comb begin
		if (scaled_win < {16'd0, seg_q}) begin
			clamped_win = {16'd0, seg_q};
		end else if (scaled_win > ceil_q) begin
			clamped_win = ceil_q;
		end else begin
			clamped_win = scaled_win;
		end
	end

	dctcp_wc_div #(
		.FRAC_BITS (F)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.marked   (acks_marked_q),
		.counted  (acks_counted_q),
		.stat     (div_st),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	assign out_load = (state_q == dctcp_wc_pkg::S_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dctcp_wc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			dctcp_wc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = dctcp_wc_pkg::S_EVAL;
				end
			end
			dctcp_wc_pkg::S_EVAL: begin
				if (op_q == dctcp_wc_pkg::OP_LOSS || byp_q) begin
					state_d = dctcp_wc_pkg::S_DONE;
				end else begin
					state_d = dctcp_wc_pkg::S_CHECK;
				end
			end
			dctcp_wc_pkg::S_CHECK: state_d = dctcp_wc_pkg::S_CMP;
			dctcp_wc_pkg::S_CMP: begin
				if (win_closed) begin
					div_start = 1'b1;
					state_d   = dctcp_wc_pkg::S_DIV;
				end else begin
					state_d = dctcp_wc_pkg::S_DONE;
				end
			end
			dctcp_wc_pkg::S_DIV: begin
				if (div_st.done) begin
					state_d = dctcp_wc_pkg::S_ALPHA;
				end
			end
			dctcp_wc_pkg::S_ALPHA: state_d = dctcp_wc_pkg::S_SCALE;
			dctcp_wc_pkg::S_SCALE: begin
				if (alpha_q == '0) begin
					state_d = dctcp_wc_pkg::S_DONE;
				end else begin
					state_d = dctcp_wc_pkg::S_CLAMP;
				end
			end
			dctcp_wc_pkg::S_CLAMP: state_d = dctcp_wc_pkg::S_DONE;
			dctcp_wc_pkg::S_DONE: begin
				if (out_load) begin
					state_d = dctcp_wc_pkg::S_IDLE;
				end
			end
			default: state_d = dctcp_wc_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Persistent state: counters, reference window, alpha
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acks_counted_q <= '0;
			acks_marked_q  <= '0;
			ref_window_q   <= dctcp_wc_pkg::INIT_WINDOW_REF_RST;
			alpha_q        <= '0;
		end else begin
			case (state_q)
				dctcp_wc_pkg::S_EVAL: begin
					if (op_q == dctcp_wc_pkg::OP_LOSS) begin
						// loss: restart the window
						acks_counted_q <= '0;
						acks_marked_q  <= '0;
						ref_window_q   <= cwnd_q;
					end else if (!byp_q) begin
						// count, saturating
						if (acks_counted_q != '1) begin
							acks_counted_q <= acks_counted_q + 32'd1;
						end
						if (ecn_q && acks_marked_q != '1) begin
							acks_marked_q <= acks_marked_q + 32'd1;
						end
					end
				end
				dctcp_wc_pkg::S_ALPHA: begin
					alpha_q        <= alpha_new;
					acks_counted_q <= '0;
					acks_marked_q  <= '0;
				end
				dctcp_wc_pkg::S_SCALE: begin
					if (alpha_q == '0) begin
						ref_window_q <= cwnd_q;
					end
				end
				dctcp_wc_pkg::S_CLAMP: ref_window_q <= clamped_win;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Event registers: capture on accept, then rewrite window/threshold
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			dctcp_wc_pkg::S_IDLE: begin
				op_q   <= op;
				ecn_q  <= ce_echo;
				byp_q  <= bypass;
				cwnd_q <= cur_window;
				ssth_q <= cur_threshold;
				upd_q  <= 1'b0;
			end
			dctcp_wc_pkg::S_EVAL: begin
				if (op_q == dctcp_wc_pkg::OP_LOSS) begin
					ssth_q <= (half_win > floor2) ? half_win : floor2;
				end else if (!byp_q && ecn_q && ssth_q > cwnd_q) begin
					// marked ACK caps ssthresh at cwnd
					ssth_q <= cwnd_q;
				end
			end
			dctcp_wc_pkg::S_ALPHA: upd_q <= 1'b1;
			dctcp_wc_pkg::S_CLAMP: begin
				cwnd_q <= clamped_win;
				ssth_q <= clamped_win;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: hold the word until taken
	// ------------------------------------------------------------------
	assign alpha_ext = {alpha_q, 16'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_window_q <= cwnd_q;
			out_thresh_q <= ssth_q;
			out_upd_q    <= upd_q;
			// rescale alpha to 16 fraction bits
			out_alpha_q  <= alpha_ext[F+15:F];
		end
	end

	assign out_valid      = out_valid_q;
	assign new_window     = out_window_q;
	assign new_threshold  = out_thresh_q;
	assign window_updated = out_upd_q;
	assign alpha_out      = out_alpha_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_marked_le_counted: assert property (@(posedge clk) disable iff (!arst_n)
		acks_marked_q <= acks_counted_q)
		else $error("marked count exceeds ACK count");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == dctcp_wc_pkg::S_DIV)
		else $error("divider finished outside the divide state");

	a_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dctcp_wc_pkg::S_ALPHA |=> acks_counted_q == '0 && acks_marked_q == '0)
		else $error("counters not cleared after alpha update");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == dctcp_wc_pkg::S_IDLE)
		else $error("result not presented after completion");

endmodule

/* src/dctcp_wc_div.sv */
// ----------------------------------------------------------------------------
// DCTCP marked fraction divider
// Restoring divider, one quotient bit per cycle: quotient = marked * 2^F /
// counted, with marked never above counted so F+1 quotient bits suffice.
// ----------------------------------------------------------------------------
module dctcp_wc_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                marked,
	input  logic [31:0]                counted,
	output dctcp_wc_pkg::div_stat_t    stat,
	output logic [FRAC_BITS:0]         quotient
);

	localparam int STEPS = FRAC_BITS + 1;
	localparam int CW    = $clog2(STEPS);

	logic [32:0]        rem_q;
	logic [31:0]        den_q;
	logic [FRAC_BITS:0] quo_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;

	logic        fits;
	logic [32:0] diff;
	logic [32:0] rem_next;

	// remainder stays below the divisor after each step, so the shift fits
	assign fits     = (rem_q >= {1'b0, den_q});
	assign diff     = rem_q - {1'b0, den_q};
	assign rem_next = fits ? {diff[31:0], 1'b0} : {rem_q[31:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, marked};
			den_q <= counted;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[FRAC_BITS-1:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

/* test/dctcp_wc_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DCTCP window control checker
// Watches the configuration port and both channels, predicts the result word
// of every accepted event and compares it with the word that leaves the block.
// ----------------------------------------------------------------------------
module dctcp_wc_checker #(
	parameter int FRAC = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        op,
	input  logic        ce_echo,
	input  logic        bypass,
	input  logic [31:0] cur_window,
	input  logic [31:0] cur_threshold,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] new_window,
	input  logic [31:0] new_threshold,
	input  logic        window_updated,
	input  logic [15:0] alpha_out,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic        kind;
		logic        echo;
		logic        skip;
		logic [31:0] cwnd;
		logic [31:0] ssth;
	} wc_event_t;

	typedef struct packed {
		logic [31:0] wnd;
		logic [31:0] thr;
		logic        upd;
		logic [15:0] alpha;
	} wc_result_t;

	localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

	// register copies
	logic [15:0] seg_len;
	logic [31:0] win_cap;
	logic [31:0] win_ref_init;

	// window accounting
	logic [31:0] ack_total;
	logic [31:0] ack_marked;
	logic [31:0] win_ref;
	logic [31:0] alpha_q;

	wc_result_t expected_words[$];

	initial fail_count = 0;
	initial pending = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic wc_result_t predict_event(input wc_event_t ev);
		wc_result_t  res;
		logic [31:0] wnd;
		logic [31:0] thr;
		logic [31:0] half;
		logic [31:0] floor2;
		logic [31:0] w;
		logic [63:0] one;
		logic [63:0] frac;
		logic [63:0] scale;
		logic [63:0] prod;
		logic        upd;
		wnd = ev.cwnd;
		thr = ev.ssth;
		upd = 1'b0;
		one = 64'd1 << FRAC;
		if (ev.kind == dctcp_wc_pkg::OP_LOSS) begin
			// loss: halve the threshold with a floor of two segments
			half = wnd >> 1;
			floor2 = 32'(seg_len) << 1;
			thr = (half > floor2) ? half : floor2;
			ack_total = '0;
			ack_marked = '0;
			win_ref = wnd;
		end else if (!ev.skip) begin
			if (ack_total != CNT_SAT)
				ack_total++;
			if (ev.echo) begin
				if (ack_marked != CNT_SAT)
					ack_marked++;
				if (thr > wnd)
					thr = wnd;
			end
			if (64'(ack_total) * 64'(seg_len) >= 64'(win_ref)) begin
				frac = (64'(ack_marked) << FRAC) / 64'(ack_total);
				if (frac > one)
					frac = one;
				alpha_q = 32'((64'd15 * 64'(alpha_q) + frac) >> 4);
				ack_total = '0;
				ack_marked = '0;
				if (alpha_q != 0) begin
					scale = (one << 1) - 64'(alpha_q);
					prod = (64'(wnd) * scale) >> (FRAC + 1);
					w = prod[31:0];
					if (w < 32'(seg_len))
						w = 32'(seg_len);
					else if (w > win_cap)
						w = win_cap;
					wnd = w;
					thr = w;
				end
				win_ref = wnd;
				upd = 1'b1;
			end
		end
		res.wnd = wnd;
		res.thr = thr;
		res.upd = upd;
		if (FRAC >= 16)
			res.alpha = 16'(alpha_q >> ((FRAC - 16) & 31));
		else
			res.alpha = 16'(alpha_q << ((16 - FRAC) & 31));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wc_event_t  ev;
		wc_result_t want;
		if (!arst_n) begin
			seg_len = dctcp_wc_pkg::SEG_SIZE_RST;
			win_cap = dctcp_wc_pkg::WINDOW_CEILING_RST;
			win_ref_init = dctcp_wc_pkg::INIT_WINDOW_REF_RST;
			ack_total = '0;
			ack_marked = '0;
			win_ref = win_ref_init;
			alpha_q = '0;
			expected_words.delete();
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					dctcp_wc_pkg::REG_SEG_SIZE:        seg_len = cfg_data[15:0];
					dctcp_wc_pkg::REG_WINDOW_CEILING:  win_cap = cfg_data;
					// only loaded into the reference window at reset
					dctcp_wc_pkg::REG_INIT_WINDOW_REF: win_ref_init = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing queued", new_window, '0);
				end else begin
					want = expected_words.pop_front();
					if (new_window !== want.wnd)
						report_mismatch("new_window", new_window, want.wnd);
					if (new_threshold !== want.thr)
						report_mismatch("new_threshold", new_threshold, want.thr);
					if (window_updated !== want.upd)
						report_mismatch("window_updated", 32'(window_updated), 32'(want.upd));
					if (alpha_out !== want.alpha)
						report_mismatch("alpha_out", 32'(alpha_out), 32'(want.alpha));
				end
			end
			if (in_valid && in_ready) begin
				ev.kind = op;
				ev.echo = ce_echo;
				ev.skip = bypass;
				ev.cwnd = cur_window;
				ev.ssth = cur_threshold;
				expected_words.push_back(predict_event(ev));
			end
			pending = expected_words.size();
		end
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DCTCP window control testbench
// Drives directed and random ACK and loss events through the window control
// under several register settings and idle patterns; a checker beside the
// block predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FRAC_BITS    = 16;
	localparam int STALL_LIMIT  = 4000;   // cycles without any accepted word
	localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
	localparam int PHASE_ITEMS  = 240;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = dctcp_wc_pkg::REG_SEG_SIZE;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = dctcp_wc_pkg::OP_ACK;
	logic        ce_echo = 1'b0;
	logic        bypass = 1'b0;
	logic [31:0] cur_window = '0;
	logic [31:0] cur_threshold = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] new_window;
	logic [31:0] new_threshold;
	logic        window_updated;
	logic [15:0] alpha_out;

	int fail_count;
	int pending;

	// idle percentages of both sides, and the hold-off request counter
	int send_idle_pct = 22;
	int recv_idle_pct = 66;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	always #10 clk = ~clk;

	dctcp_window_control #(
		.ALPHA_FRAC_BITS(FRAC_BITS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.ce_echo        (ce_echo),
		.bypass         (bypass),
		.cur_window     (cur_window),
		.cur_threshold  (cur_threshold),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.new_window     (new_window),
		.new_threshold  (new_threshold),
		.window_updated (window_updated),
		.alpha_out      (alpha_out)
	);

	dctcp_wc_checker #(
		.FRAC(FRAC_BITS)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.ce_echo        (ce_echo),
		.bypass         (bypass),
		.cur_window     (cur_window),
		.cur_threshold  (cur_threshold),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.new_window     (new_window),
		.new_threshold  (new_threshold),
		.window_updated (window_updated),
		.alpha_out      (alpha_out),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// Receiver: drop ready at random, or hold it low for a long stretch when
	// the stimulus asks, so the output register and the sequencer fill up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: end the run when no word moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offer one event word; called at a falling edge, returns at the falling
	// edge after the word was taken. Valid stays high for a following word.
	task automatic send_event(input logic kind, input logic echo, input logic skip,
		input logic [31:0] wnd, input logic [31:0] thr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		ce_echo <= echo;
		bypass <= skip;
		cur_window <= wnd;
		cur_threshold <= thr;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// A window of a few segments keeps the per-window update frequent.
	function automatic logic [31:0] few_segments(input logic [15:0] mss);
		return 32'(mss) * $urandom_range(1, 12) + $urandom_range(mss);
	endfunction

	task automatic send_random(input logic [15:0] mss, input int mark_pct);
		int          r;
		logic        kind;
		logic        echo;
		logic        skip;
		logic [31:0] wnd;
		logic [31:0] thr;
		r = $urandom_range(99);
		kind = dctcp_wc_pkg::OP_ACK;
		skip = 1'b0;
		echo = ($urandom_range(99) < mark_pct);
		if (r < 8) begin
			// loss, mostly with a small window so the reference window recovers
			kind = dctcp_wc_pkg::OP_LOSS;
			echo = 1'($urandom_range(1));
			skip = 1'($urandom_range(1));
			wnd = ($urandom_range(9) == 0) ? $urandom() : few_segments(mss);
		end else if (r < 13) begin
			skip = 1'b1;
			echo = 1'($urandom_range(1));
			wnd = $urandom();
		end else begin
			r = $urandom_range(99);
			if (r < 5)
				wnd = $urandom();
			else if (r < 12)
				wnd = $urandom_range(mss);
			else
				wnd = few_segments(mss);
		end
		thr = $urandom_range(1) ? $urandom() : wnd + $urandom_range(mss) - (mss >> 1);
		send_event(kind, echo, skip, wnd, thr);
	endtask

	task automatic configure(input logic [15:0] mss, input logic [31:0] ceiling,
		input logic [31:0] ref_init);
		cfg_wr_en <= 1'b1;
		cfg_index <= dctcp_wc_pkg::REG_SEG_SIZE;
		cfg_data <= {16'd0, mss};
		@(negedge clk);
		cfg_index <= dctcp_wc_pkg::REG_WINDOW_CEILING;
		cfg_data <= ceiling;
		@(negedge clk);
		cfg_index <= dctcp_wc_pkg::REG_INIT_WINDOW_REF;
		cfg_data <= ref_init;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Hold the input off until every queued result word has left the block.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	initial begin
		logic [15:0] mss;
		logic [31:0] ceiling;
		logic [31:0] ref_init;
		int          mark_pct;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed events on the reset settings (reference window 3000).
		// Three unmarked ACKs close the window with alpha still zero.
		send_event(dctcp_wc_pkg::OP_ACK, 1'b0, 1'b0, 32'd3000, 32'hFFFF_FFFF);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b0, 1'b0, 32'd3000, 32'd3000);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b0, 1'b0, 32'd3000, 32'd0);
		// loss ignoring echo and bypass, threshold at the two-segment floor
		send_event(dctcp_wc_pkg::OP_LOSS, 1'b1, 1'b1, 32'd2000, 32'hFFFF_FFFF);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0);
		// marked ACK caps the threshold, then a marked window clamps to ceiling
		send_event(dctcp_wc_pkg::OP_ACK, 1'b1, 1'b0, 32'd5000, 32'hFFFF_FFFF);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0);
		send_event(dctcp_wc_pkg::OP_LOSS, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'd0);
		send_event(dctcp_wc_pkg::OP_LOSS, 1'b0, 1'b0, 32'd0, 32'd7);
		// zero window at the boundary clamps up to one segment
		send_event(dctcp_wc_pkg::OP_ACK, 1'b0, 1'b0, 32'd0, 32'd123);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b1, 1'b0, 32'd20000, 32'd10000);
		send_event(dctcp_wc_pkg::OP_LOSS, 1'b0, 1'b0, 32'd5744, 32'd5744);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b1, 1'b0, 32'd5744, 32'd9000);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b0, 1'b0, 32'd5744, 32'd100);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b1, 1'b0, 32'd5744, 32'd5744);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b0, 1'b0, 32'd5744, 32'hFFFF_FFFF);
		send_event(dctcp_wc_pkg::OP_ACK, 1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF);

		for (int phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: begin
					mss = dctcp_wc_pkg::SEG_SIZE_RST;
					ceiling = dctcp_wc_pkg::WINDOW_CEILING_RST;
					ref_init = dctcp_wc_pkg::INIT_WINDOW_REF_RST;
					mark_pct = 30;
				end
				1: begin
					mss = 16'd1; ceiling = 32'hFFFF_FFFF; ref_init = '0; mark_pct = 50;
				end
				2: begin
					mss = 16'hFFFF; ceiling = 32'd1; ref_init = 32'hFFFF_FFFF;
					mark_pct = 100;
				end
				3: begin
					mss = 16'($urandom_range(1, 9000)); ceiling = $urandom();
					ref_init = $urandom(); mark_pct = 0;
				end
				4: begin
					mss = 16'd536; ceiling = 32'd262144; ref_init = $urandom();
					mark_pct = 10;
				end
				default: begin
					mss = 16'($urandom_range(1, 9000)); ceiling = $urandom();
					ref_init = $urandom(); mark_pct = 60;
				end
			endcase
			if (ceiling == 0)
				ceiling = 32'd1;
			// idle pattern: sender light / receiver heavy, then swapped, then none
			case (phase / 2)
				0: begin send_idle_pct <= 22; recv_idle_pct <= 66; end
				1: begin send_idle_pct <= 66; recv_idle_pct <= 22; end
				default: begin send_idle_pct <= 0; recv_idle_pct <= 0; end
			endcase
			configure(mss, ceiling, ref_init);
			if (phase == 5)
				hold_req <= hold_req + 1;
			repeat (PHASE_ITEMS) send_random(mss, mark_pct);
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
src/dctcp_wc_pkg.sv
src/dctcp_wc_div.sv
src/dctcp_window_control.sv
test/dctcp_wc_checker.sv
test/tb_top.sv
